@@ sv/ltwq_pkg.sv @@
// ltwq_pkg: constants, codes and types for the lock table with wait queues
// no dependencies; used by every module of the block by scoped names
package ltwq_pkg;
  localparam int LockSlots  = 16;
  localparam int QueueDepth = 8;
  localparam int SlotW      = $clog2(LockSlots);
  localparam int QPosW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CountW     = $clog2(QueueDepth + 1);
  localparam int FifoDepth  = LockSlots * QueueDepth;
  localparam int FifoAddrW  = $clog2(FifoDepth);

  typedef enum logic [1:0] {
    ACT_ACQUIRE = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_QUERY   = 2'd2,
    ACT_SPARE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    LK_FREE    = 2'd0,
    LK_LOCKED  = 2'd1,
    LK_WAITING = 2'd2
  } lock_state_e;

  typedef enum logic [2:0] {
    RS_OK         = 3'd0,
    RS_RETRY      = 3'd1,
    RS_NOT_HOLDER = 3'd2,
    RS_UNKNOWN    = 3'd3,
    RS_TABLE_FULL = 3'd4,
    RS_QUEUE_FULL = 3'd5
  } status_e;

  // search result handed from the scanner to the sequencer
  typedef struct packed {
    logic             hit;
    logic [SlotW-1:0] hit_slot;
    logic             free_found;
    logic [SlotW-1:0] free_slot;
  } scan_res_t;
endpackage

@@ sv/ltwq_scan.sv @@
// ltwq_scan: sequential id compare over the slot id memory, one slot a cycle
// depends on ltwq_pkg
module ltwq_scan (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             go_i,
  input  logic [63:0]                      id_i,
  input  logic [ltwq_pkg::LockSlots-1:0]   valid_i,
  input  logic                             wr_i,
  input  logic [ltwq_pkg::SlotW-1:0]       wr_slot_i,
  output logic                             done_o,
  output ltwq_pkg::scan_res_t              res_o
);
  logic [63:0] id_mem [ltwq_pkg::LockSlots];
  logic [63:0] rd_q;
  logic [ltwq_pkg::SlotW-1:0] rd_idx_q, cmp_idx_q;
  logic rd_v_q, cmp_v_q, run_q, last_q;
  ltwq_pkg::scan_res_t res_q;
  logic last_rd;

  assign last_rd = (rd_idx_q == ltwq_pkg::SlotW'(ltwq_pkg::LockSlots - 1));

  always_ff @(posedge clk_i) begin
    if (wr_i) id_mem[wr_slot_i] <= id_i;
    rd_q <= id_mem[rd_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0; cmp_idx_q <= '0; rd_v_q <= 1'b0; cmp_v_q <= 1'b0;
      run_q <= 1'b0; last_q <= 1'b0; res_q <= '0; done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      cmp_v_q <= rd_v_q; cmp_idx_q <= rd_idx_q; last_q <= rd_v_q && last_rd;
      rd_v_q <= 1'b0;
      if (go_i) begin
        run_q <= 1'b1; rd_idx_q <= '0; rd_v_q <= 1'b1; res_q <= '0;
      end else if (run_q) begin
        if (rd_v_q && !last_rd) begin
          rd_idx_q <= rd_idx_q + 1'b1; rd_v_q <= 1'b1;
        end
        if (cmp_v_q) begin
          if (valid_i[cmp_idx_q] && rd_q == id_i && !res_q.hit) begin
            res_q.hit <= 1'b1; res_q.hit_slot <= cmp_idx_q;
          end
          if (!valid_i[cmp_idx_q] && !res_q.free_found) begin
            res_q.free_found <= 1'b1; res_q.free_slot <= cmp_idx_q;
          end
          if (last_q) begin
            run_q <= 1'b0; done_o <= 1'b1;
          end
        end
      end
    end
  end

  assign res_o = res_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !run_q) else $error("scan done while running");
  a_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_q.hit |-> valid_i[res_q.hit_slot]) else $error("hit on invalid slot");
  a_free_inv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_q.free_found |-> !valid_i[res_q.free_slot]) else $error("bad free slot");
endmodule

@@ sv/lock_table_with_wait_queues.sv @@
// lock_table_with_wait_queues: top level, sequencer, slot state and wait queue memory
// depends on ltwq_pkg and ltwq_scan
//
//  channel | handshake            | payload
//  command | start_i, busy_o      | action_i, lock_id_i, client_i
//  result  | done_o (one cycle)   | status_o, lock_state_o, holder_o, holder_valid_o,
//          |                      | waiting_count_o, revoke_needed_o
//
// an item runs from start to done through the id scan, which reads one slot a cycle
// from the id memory, then a queue memory read and the update; busy_o stays high
// until done_o rises
// reset clears slot valid bits, states, queue heads and counts at once
// the receiver cannot stall: the result is shown for one cycle with done_o
module lock_table_with_wait_queues (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [63:0] lock_id_i,
  input  logic [7:0]  client_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [1:0]  lock_state_o,
  output logic [7:0]  holder_o,
  output logic        holder_valid_o,
  output logic [3:0]  waiting_count_o,
  output logic        revoke_needed_o
);
  localparam int NS = ltwq_pkg::LockSlots;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_READ  = 5'b00100,
    S_EXEC  = 5'b01000,
    S_OUT   = 5'b10000
  } seq_e;

  seq_e seq_q;
  // latched command
  logic [1:0]  act_q;
  logic [63:0] id_q;
  logic [7:0]  who_q;
  // per slot state
  logic [NS-1:0] valid_q;
  logic [1:0]    st_q   [NS];
  logic [7:0]    hold_q [NS];
  logic [ltwq_pkg::QPosW-1:0]  head_q [NS];
  logic [ltwq_pkg::CountW-1:0] cnt_q  [NS];
  // wait queue memory
  logic [7:0] fifo_mem [ltwq_pkg::FifoDepth];
  logic [7:0] fifo_rd_q;
  logic       fifo_we;
  logic [ltwq_pkg::FifoAddrW-1:0] fifo_wa, fifo_ra;

  logic scan_go, scan_done, id_wr;
  ltwq_pkg::scan_res_t sres;
  logic [ltwq_pkg::SlotW-1:0] slot_q;
  logic found_q;

  ltwq_scan u_scan (
    .clk_i, .rst_ni, .go_i(scan_go), .id_i(id_q), .valid_i(valid_q),
    .wr_i(id_wr), .wr_slot_i(slot_q), .done_o(scan_done), .res_o(sres)
  );

  assign scan_go = (seq_q == S_IDLE) && start_i;
  assign busy_o  = (seq_q != S_IDLE);

  // slot chosen after the scan: a hit, else a claim on acquire
  logic [ltwq_pkg::SlotW-1:0] s_pick;
  logic s_found, s_claim;
  always_comb begin
    s_found = sres.hit;
    s_pick  = sres.hit ? sres.hit_slot : sres.free_slot;
    s_claim = !sres.hit && sres.free_found && (act_q == ltwq_pkg::ACT_ACQUIRE);
  end

  // current slot view (claimed slots read as a fresh free lock)
  logic [1:0] cur_st;
  logic [7:0] cur_hold;
  logic [ltwq_pkg::QPosW-1:0]  cur_head;
  logic [ltwq_pkg::CountW-1:0] cur_cnt;
  always_comb begin
    cur_st   = st_q[slot_q];
    cur_hold = hold_q[slot_q];
    cur_head = head_q[slot_q];
    cur_cnt  = cnt_q[slot_q];
  end

  logic [ltwq_pkg::QPosW-1:0] tail;
  assign tail = ltwq_pkg::QPosW'((32'(cur_head) + 32'(cur_cnt)) % ltwq_pkg::QueueDepth);

  always_comb begin
    fifo_wa = ltwq_pkg::FifoAddrW'(32'(slot_q) * ltwq_pkg::QueueDepth + 32'(tail));
    fifo_ra = ltwq_pkg::FifoAddrW'(32'(slot_q) * ltwq_pkg::QueueDepth + 32'(cur_head));
  end

  always_ff @(posedge clk_i) begin
    if (fifo_we) fifo_mem[fifo_wa] <= who_q;
    fifo_rd_q <= fifo_mem[fifo_ra];
  end

  // update decision in S_EXEC
  logic [2:0] stat;
  always_comb begin
    fifo_we = 1'b0;
    stat    = ltwq_pkg::RS_OK;
    if (seq_q == S_EXEC && found_q) begin
      case (act_q)
        ltwq_pkg::ACT_ACQUIRE: begin
          if (cur_st == ltwq_pkg::LK_FREE) stat = ltwq_pkg::RS_OK;
          else if (cur_st == ltwq_pkg::LK_WAITING && cur_hold == who_q) stat = ltwq_pkg::RS_OK;
          else if (32'(cur_cnt) >= ltwq_pkg::QueueDepth) stat = ltwq_pkg::RS_QUEUE_FULL;
          else begin
            stat = ltwq_pkg::RS_RETRY; fifo_we = 1'b1;
          end
        end
        ltwq_pkg::ACT_RELEASE: begin
          if (cur_st == ltwq_pkg::LK_FREE || cur_hold != who_q) stat = ltwq_pkg::RS_NOT_HOLDER;
          else stat = ltwq_pkg::RS_OK;
        end
        default: stat = ltwq_pkg::RS_OK;
      endcase
    end else if (seq_q == S_EXEC) begin
      case (act_q)
        ltwq_pkg::ACT_ACQUIRE: stat = ltwq_pkg::RS_TABLE_FULL;
        ltwq_pkg::ACT_RELEASE: stat = ltwq_pkg::RS_UNKNOWN;
        default:               stat = ltwq_pkg::RS_OK;
      endcase
    end
  end

  assign id_wr = (seq_q == S_READ) && found_q && !valid_q[slot_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= S_IDLE; valid_q <= '0; found_q <= 1'b0; slot_q <= '0;
      done_o <= 1'b0; status_o <= '0; lock_state_o <= '0; holder_o <= '0;
      holder_valid_o <= 1'b0; waiting_count_o <= '0; revoke_needed_o <= 1'b0;
      act_q <= '0; id_q <= '0; who_q <= '0;
      for (int i = 0; i < NS; i++) begin
        st_q[i] <= ltwq_pkg::LK_FREE; head_q[i] <= '0; cnt_q[i] <= '0; hold_q[i] <= '0;
      end
    end else begin
      done_o <= 1'b0;
      case (seq_q)
        S_IDLE: if (start_i) begin
          act_q <= action_i; id_q <= lock_id_i; who_q <= client_i; seq_q <= S_SCAN;
        end
        S_SCAN: if (scan_done) begin
          slot_q  <= s_pick;
          found_q <= s_found || s_claim;
          seq_q   <= S_READ;
        end
        S_READ: begin
          // claim a new slot as a fresh free lock; the queue head read settles here
          if (found_q && !valid_q[slot_q]) begin
            valid_q[slot_q] <= 1'b1; st_q[slot_q] <= ltwq_pkg::LK_FREE;
            hold_q[slot_q] <= '0; head_q[slot_q] <= '0; cnt_q[slot_q] <= '0;
          end
          seq_q <= S_EXEC;
        end
        S_EXEC: begin
          status_o <= stat;
          if (found_q) begin
            if (act_q == ltwq_pkg::ACT_ACQUIRE && stat == ltwq_pkg::RS_OK) begin
              st_q[slot_q] <= ltwq_pkg::LK_LOCKED;
              if (cur_st == ltwq_pkg::LK_FREE) hold_q[slot_q] <= who_q;
            end
            if (fifo_we) cnt_q[slot_q] <= cur_cnt + 1'b1;
            if (act_q == ltwq_pkg::ACT_RELEASE && stat == ltwq_pkg::RS_OK) begin
              if (cur_cnt == '0) begin
                st_q[slot_q] <= ltwq_pkg::LK_FREE; hold_q[slot_q] <= '0;
              end else begin
                hold_q[slot_q] <= fifo_rd_q; st_q[slot_q] <= ltwq_pkg::LK_WAITING;
                head_q[slot_q] <= ltwq_pkg::QPosW'((32'(cur_head) + 1) % ltwq_pkg::QueueDepth);
                cnt_q[slot_q]  <= cur_cnt - 1'b1;
              end
            end
          end
          seq_q <= S_OUT;
        end
        S_OUT: begin
          // report from the updated slot
          done_o <= 1'b1;
          if (found_q) begin
            lock_state_o    <= cur_st;
            holder_valid_o  <= (cur_st != ltwq_pkg::LK_FREE);
            holder_o        <= (cur_st != ltwq_pkg::LK_FREE) ? cur_hold : 8'd0;
            waiting_count_o <= 4'(cur_cnt);
            revoke_needed_o <= (cur_cnt != '0);
          end else begin
            lock_state_o <= '0; holder_valid_o <= 1'b0; holder_o <= '0;
            waiting_count_o <= '0; revoke_needed_o <= 1'b0;
          end
          seq_q <= S_IDLE;
        end
        default: seq_q <= S_IDLE;
      endcase
    end
  end

  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> seq_q == S_IDLE) else $error("result while busy");
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q[slot_q]) <= ltwq_pkg::QueueDepth) else $error("queue count overflow");
  a_start_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> seq_q == S_SCAN) else $error("start not taken");
endmodule
